@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the touch event coalescer modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds on every clock edge outside reset
`define TECF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define TECF_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define TECF_ASSERT(label, clk, rst, prop, msg)
`define TECF_NEVER(label, clk, rst, cond, msg)

`endif

`endif

@@ src/tecf_pkg.sv @@
// ---------------------------------------------------------------------------
// tecf_pkg
// Types, codes and sizes shared by the touch event coalescer modules.
// ---------------------------------------------------------------------------
package tecf_pkg;

   // Queue sizing
   localparam int QUEUE_DEPTH = 128;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int ACT_W     = 2;
   localparam int CONTACT_W = 8;
   localparam int COORD_W   = 16;
   localparam int STAT_W    = 2;
   localparam int FILL_W    = 8;
   localparam int TICK_W    = 16;

   // Reset and saturation values
   localparam logic [TICK_W-1:0] FLUSH_RESET = TICK_W'(10);
   localparam logic [TICK_W-1:0] TICKS_MAX   = '1;

   // Action codes
   localparam logic [ACT_W-1:0] ACT_REPORT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_TICK   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_POP    = 2'd2;

   // Response status codes
   localparam logic [STAT_W-1:0] ST_ACK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_POPPED = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;

   // One queued event
   typedef struct packed {
      logic               contact;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } event_type;

   // Controller to datapath commands
   typedef struct packed {
      logic exec;      // run the accepted transaction
      logic push2;     // push the held contact edge event
      logic load_out;  // load the response register
   } tecf_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic two_push;  // incoming transaction needs a second queue write
   } tecf_sts_type;

endpackage

@@ src/tecf_dp.sv @@
// ---------------------------------------------------------------------------
// tecf_dp
// Datapath: touch tracking, move coalescing, event queue and response register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tecf_dp
   import tecf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  tecf_cmd_type         cmd,
   output tecf_sts_type         sts,
   input  logic [ACT_W-1:0]     req_action,
   input  logic [CONTACT_W-1:0] req_contact,
   input  logic [COORD_W-1:0]   req_x_pos,
   input  logic [COORD_W-1:0]   req_y_pos,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [TICK_W-1:0]    csr_wdata,
   output logic [STAT_W-1:0]    rsp_status,
   output logic                 rsp_event_contact,
   output logic [COORD_W-1:0]   rsp_event_x,
   output logic [COORD_W-1:0]   rsp_event_y,
   output logic [FILL_W-1:0]    rsp_fill_level
);

   // Event store
   event_type mem [QUEUE_DEPTH];

   logic [TICK_W-1:0]  interval_ff, interval_in;
   logic [TICK_W-1:0]  ticks_ff, ticks_in;
   logic               touching_ff, touching_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [COORD_W-1:0] pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic [COORD_W-1:0] last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [STAT_W-1:0]  stat_ff, stat_in;
   logic               down_ff, down_in;
   logic [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   event_type          rd_data_ff;
   event_type          out_evt_ff;
   logic [STAT_W-1:0]  out_stat_ff;
   logic [FILL_W-1:0]  out_fill_ff;

   logic               down;
   logic               is_edge;
   logic               push_en;
   event_type          push_evt;
   logic               rd_en;
   logic [TICK_W-1:0]  tick_inc;
   logic [COORD_W-1:0] cmp_x, cmp_y;

   // Advance a queue pointer with wrap
   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Decode the report against the current touch state
   assign down         = |req_contact;
   assign is_edge      = (req_action == ACT_REPORT) && (down != touching_ff);
   assign sts.two_push = is_edge && pend_valid_ff;
   assign tick_inc     = (ticks_ff == TICKS_MAX) ? ticks_ff : ticks_ff + 1'b1;
   assign cmp_x        = pend_valid_ff ? pend_x_ff : last_x_ff;
   assign cmp_y        = pend_valid_ff ? pend_y_ff : last_y_ff;

   // Next-state logic for one transaction step
   always_comb begin
      interval_in   = interval_ff;
      ticks_in      = ticks_ff;
      touching_in   = touching_ff;
      pend_valid_in = pend_valid_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      last_x_in     = last_x_ff;
      last_y_in     = last_y_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      count_in      = count_ff;
      stat_in       = stat_ff;
      down_in       = down_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      push_en       = 1'b0;
      push_evt      = '0;
      rd_en         = 1'b0;

      if (csr_valid && csr_ready) begin
         interval_in = csr_wdata;
      end

      if (cmd.exec) begin
         down_in = down;
         x_in    = req_x_pos;
         y_in    = req_y_pos;
         stat_in = ST_ACK;
         case (req_action)
            ACT_REPORT: begin
               if (is_edge) begin
                  // Flush any pending move first, edge event follows
                  ticks_in      = '0;
                  touching_in   = down;
                  pend_valid_in = 1'b0;
                  push_en       = 1'b1;
                  if (pend_valid_ff) begin
                     push_evt = '{contact: 1'b1, x: pend_x_ff, y: pend_y_ff};
                  end else begin
                     push_evt = '{contact: down, x: req_x_pos, y: req_y_pos};
                  end
               end else if (down && ((cmp_x != req_x_pos) || (cmp_y != req_y_pos))) begin
                  // Coalesce the move
                  pend_x_in     = req_x_pos;
                  pend_y_in     = req_y_pos;
                  pend_valid_in = 1'b1;
               end
            end
            ACT_TICK: begin
               ticks_in = tick_inc;
               if (pend_valid_ff && (tick_inc >= interval_ff)) begin
                  ticks_in      = '0;
                  pend_valid_in = 1'b0;
                  push_en       = 1'b1;
                  push_evt      = '{contact: 1'b1, x: pend_x_ff, y: pend_y_ff};
               end
            end
            ACT_POP: begin
               if (count_ff != '0) begin
                  rd_en     = 1'b1;
                  rd_ptr_in = next_ptr(rd_ptr_ff);
                  count_in  = count_ff - 1'b1;
                  stat_in   = ST_POPPED;
               end else begin
                  stat_in = ST_EMPTY;
               end
            end
            default: begin
            end
         endcase
      end

      // Second write of an edge that flushed a pending move
      if (cmd.push2) begin
         push_en  = 1'b1;
         push_evt = '{contact: down_ff, x: x_ff, y: y_ff};
      end

      // Queue write, drop the oldest entry when full
      if (push_en) begin
         wr_ptr_in = next_ptr(wr_ptr_ff);
         last_x_in = push_evt.x;
         last_y_in = push_evt.y;
         if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
            rd_ptr_in = next_ptr(rd_ptr_ff);
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff   <= FLUSH_RESET;
         ticks_ff      <= TICKS_MAX;
         touching_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         pend_x_ff     <= '0;
         pend_y_ff     <= '0;
         last_x_ff     <= '0;
         last_y_ff     <= '0;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         count_ff      <= '0;
         stat_ff       <= ST_ACK;
      end else begin
         interval_ff   <= interval_in;
         ticks_ff      <= ticks_in;
         touching_ff   <= touching_in;
         pend_valid_ff <= pend_valid_in;
         pend_x_ff     <= pend_x_in;
         pend_y_ff     <= pend_y_in;
         last_x_ff     <= last_x_in;
         last_y_ff     <= last_y_in;
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         count_ff      <= count_in;
         stat_ff       <= stat_in;
      end
   end

   // Hold the transaction fields for the second write
   always_ff @(posedge clock) begin
      down_ff <= down_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
   end

   // Event store write and registered read
   always_ff @(posedge clock) begin
      if (push_en) begin
         mem[wr_ptr_ff] <= push_evt;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   // Response register, event fields zero unless popped
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_stat_ff <= stat_ff;
         out_evt_ff  <= (stat_ff == ST_POPPED) ? rd_data_ff : '0;
         out_fill_ff <= FILL_W'(count_ff);
      end
   end

   assign rsp_status        = out_stat_ff;
   assign rsp_event_contact = out_evt_ff.contact;
   assign rsp_event_x       = out_evt_ff.x;
   assign rsp_event_y       = out_evt_ff.y;
   assign rsp_fill_level    = out_fill_ff;

   `TECF_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(QUEUE_DEPTH), "queue count over depth")
   `TECF_ASSERT(a_empty_ptrs, clock, reset, (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff), "empty queue with pointers apart")
   `TECF_ASSERT(a_pend_touch, clock, reset, pend_valid_ff |-> touching_ff, "pending move without contact")
   `TECF_ASSERT(a_empty_pop, clock, reset, (cmd.exec && (req_action == ACT_POP) && (count_ff == '0)) |=> $stable(rd_ptr_ff), "pop on empty moved read pointer")

endmodule

@@ src/tecf_ctrl.sv @@
// ---------------------------------------------------------------------------
// tecf_ctrl
// Controller: sequences each transaction and owns the req and rsp handshakes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tecf_ctrl
   import tecf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  tecf_sts_type sts,
   output tecf_cmd_type cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_PUSH2 = 2'd1;
   localparam logic [1:0] S_DONE  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequence the transaction steps
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.exec = 1'b1;
               state_in = sts.two_push ? S_PUSH2 : S_DONE;
            end
         end
         S_PUSH2: begin
            cmd.push2 = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `TECF_ASSERT(a_push2_done, clock, reset, (state_ff == S_PUSH2) |=> (state_ff == S_DONE), "second write not followed by response")
   `TECF_ASSERT(a_load_free, clock, reset, cmd.load_out |-> out_free, "response register overwritten")
   `TECF_ASSERT(a_busy_after, clock, reset, $past(cmd.exec && !reset) |-> !req_ready, "transaction accepted while busy")

endmodule

@@ src/touch_event_coalescer_fifo.sv @@
// ---------------------------------------------------------------------------
// touch_event_coalescer_fifo
// Touch event coalescer with a 128-entry overwrite-oldest event queue.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  req      in         req_valid/req_ready    action, contact, x_pos, y_pos
//  rsp      out        rsp_valid/rsp_ready    status, event fields, fill_level
//  csr      in         csr_valid/csr_ready    flush_interval (16 bit)
//
//  A transaction first updates state and accesses the queue, then loads
//  the response register. A contact edge that flushes a pending move adds
//  a second queue write step, since the single write port stores two events.
//  A new transaction is accepted while the previous response waits; a stalled
//  response holds the block in its load step. Reset is synchronous and
//  needs no clearing pass. csr writes are always accepted.
// ---------------------------------------------------------------------------
module touch_event_coalescer_fifo
   import tecf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ACT_W-1:0]     req_action,
   input  logic [CONTACT_W-1:0] req_contact,
   input  logic [COORD_W-1:0]   req_x_pos,
   input  logic [COORD_W-1:0]   req_y_pos,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STAT_W-1:0]    rsp_status,
   output logic                 rsp_event_contact,
   output logic [COORD_W-1:0]   rsp_event_x,
   output logic [COORD_W-1:0]   rsp_event_y,
   output logic [FILL_W-1:0]    rsp_fill_level,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [TICK_W-1:0]    csr_wdata
);

   tecf_cmd_type cmd;
   tecf_sts_type sts;

   assign csr_ready = 1'b1;

   tecf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tecf_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_action        (req_action),
      .req_contact       (req_contact),
      .req_x_pos         (req_x_pos),
      .req_y_pos         (req_y_pos),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata),
      .rsp_status        (rsp_status),
      .rsp_event_contact (rsp_event_contact),
      .rsp_event_x       (rsp_event_x),
      .rsp_event_y       (rsp_event_y),
      .rsp_fill_level    (rsp_fill_level)
   );

endmodule
